>>> hdl/crfb_pkg.sv
// Shared types and constants for the circle raster frame buffer.
package crfb_pkg;

    localparam int CH_W      = 8;
    localparam int COORD_W   = 11;
    localparam int RAD_W     = 16;
    localparam int IDX_W     = 16;
    localparam int CFG_W     = 9;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;
    localparam int DX_W      = 12;
    localparam int DX2_W     = 22;
    localparam int D2_W      = 23;
    localparam int S_TDATA_W = 72;

    localparam int OFS_ACTION = 0;
    localparam int OFS_CX     = 2;
    localparam int OFS_CY     = 13;
    localparam int OFS_RADIUS = 24;
    localparam int OFS_FILLED = 40;
    localparam int OFS_CHAR   = 41;
    localparam int OFS_IDX    = 49;

    localparam logic [RAD_W-1:0] RADIUS_ONE = 16'd256;

    localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_READ_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_cell;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/crfb_ctrl.sv
// Controller state machine: sequences clear, draw sweep and cell read.
module crfb_ctrl
    import crfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    input  t_dp_stat   i_stat,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (t_action'(i_action))
                        ACT_CLEAR, ACT_DRAW: n_state = ST_SETUP;
                        ACT_READ:            n_state = ST_READ;
                        ACT_NONE:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP:     n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (i_stat.last_cell) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_SETUP:     o_cmd.setup    = 1'b1;
            ST_SWEEP:     o_cmd.step     = 1'b1;
            ST_DRAIN:     o_cmd          = '0;
            ST_READ:      o_cmd          = '0;
            ST_READ_WAIT: o_cmd.out_load = i_stat.out_free;
            default:      o_cmd          = '0;
        endcase
    end

endmodule

>>> hdl/crfb_dp.sv
// Datapath: frame buffer memory, cell sweep counters, distance test, output register.
module crfb_dp
    import crfb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [CFG_W-1:0]     i_cfg_width,
    input  logic [CFG_W-1:0]     i_cfg_height,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [CH_W-1:0]      o_m_tdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    logic [CH_W-1:0] mem [DEPTH];

    int w_eff;
    int h_eff;
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [NW-1:0] r_cells;

    logic                       r_clear;
    logic signed [COORD_W-1:0]  r_cx;
    logic signed [COORD_W-1:0]  r_cy;
    logic [RAD_W-1:0]           r_radius;
    logic                       r_filled;
    logic [CH_W-1:0]            r_char;
    logic [IDX_W-1:0]           r_idx;

    logic [RAD_W-1:0]   r_rr_hi;
    logic [RAD_W-1:0]   r_inner_hi;
    logic               r_thin;
    logic [2*RAD_W-1:0] rr;
    logic [2*RAD_W-1:0] inner;
    logic [RAD_W-1:0]   rad_m1;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_addr;

    logic signed [DX_W-1:0]   dx;
    logic signed [DX_W-1:0]   dy;
    logic signed [2*DX_W-1:0] dx_sq;
    logic signed [2*DX_W-1:0] dy_sq;

    logic             r_a_valid;
    logic [AW-1:0]    r_a_addr;
    logic [DX2_W-1:0] r_a_dx2;
    logic [DX2_W-1:0] r_a_dy2;

    logic [D2_W-1:0] d2;
    logic            in_disc;
    logic            beyond;
    logic            wen;

    logic [CH_W-1:0] r_rd_data;
    logic            idx_ok;
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_data;

    always_comb begin
        if (i_cfg_width == '0) begin
            w_eff = 1;
        end else if (int'(i_cfg_width) > MAX_WIDTH) begin
            w_eff = MAX_WIDTH;
        end else begin
            w_eff = int'(i_cfg_width);
        end
        if (i_cfg_height == '0) begin
            h_eff = 1;
        end else if (int'(i_cfg_height) > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end else begin
            h_eff = int'(i_cfg_height);
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_col <= CW'(w_eff - 1);
        r_last_row <= RW'(h_eff - 1);
        r_cells    <= NW'(w_eff * h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clear  <= (i_s_tdata[OFS_ACTION +: 2] == ACT_CLEAR);
            r_cx     <= $signed(i_s_tdata[OFS_CX +: COORD_W]);
            r_cy     <= $signed(i_s_tdata[OFS_CY +: COORD_W]);
            r_radius <= i_s_tdata[OFS_RADIUS +: RAD_W];
            r_filled <= i_s_tdata[OFS_FILLED];
            r_char   <= i_s_tdata[OFS_CHAR +: CH_W];
            r_idx    <= i_s_tdata[OFS_IDX +: IDX_W];
        end
    end

    assign rad_m1 = r_radius - RADIUS_ONE;
    assign rr     = r_radius * r_radius;
    assign inner  = rad_m1 * rad_m1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_rr_hi    <= rr[2*RAD_W-1:RAD_W];
            r_inner_hi <= inner[2*RAD_W-1:RAD_W];
            r_thin     <= (r_radius < RADIUS_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= '0;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + AW'(1);
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign dx    = $signed({r_cx[COORD_W-1], r_cx}) - $signed(DX_W'(r_col));
    assign dy    = $signed({r_cy[COORD_W-1], r_cy}) - $signed(DX_W'(r_row));
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_addr <= r_addr;
        r_a_dx2  <= DX2_W'(dx_sq);
        r_a_dy2  <= DX2_W'(dy_sq);
    end

    assign d2      = D2_W'(r_a_dx2) + D2_W'(r_a_dy2);
    assign in_disc = (d2 <= D2_W'(r_rr_hi));
    assign beyond  = r_thin || (d2 > D2_W'(r_inner_hi));
    assign wen     = r_a_valid && (r_clear || (in_disc && (r_filled || beyond)));

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[r_a_addr] <= r_char;
        end
        r_rd_data <= mem[AW'(r_idx)];
    end

    assign idx_ok = (32'(r_idx) < 32'(r_cells));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= idx_ok ? r_rd_data : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_stat.last_cell = (r_col == r_last_col) && (r_row == r_last_row);
    assign o_stat.pipe_busy = r_a_valid;
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

endmodule

>>> hdl/circle_raster_frame_buffer.sv
// Top level: character frame buffer with circle rasterizer and register port.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata: action, center_x, center_y, radius,
//           |     |                    |          filled, paint_char, cell_index
//   m_*     | out | m_tvalid/m_tready  | m_tdata: cell_char
//   apb     | in  | psel/penable       | 0x0 grid_width, 0x4 grid_height
//
// Clear and draw sweep every cell of the grid before the next beat is accepted:
// one cell per cycle through the sweep counters and the single write port of the frame buffer.
// Read fetches the indexed cell into a register, then waits for the output register to drain.
// Reset clears control only; frame buffer contents are undefined until written.
// m_tready low holds the result and stalls only a following read.
module circle_raster_frame_buffer
    import crfb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] action, [12:2] center_x, [23:13] center_y, [39:24] radius,
    // [40] filled, [48:41] paint_char, [64:49] cell_index, [71:65] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] cell_char
    output logic [CH_W-1:0]      m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]     pwdata,
    output logic [APB_W-1:0]     prdata,
    output logic                 pready
);

    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic             cfg_wr;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID_WIDTH) begin
                r_grid_width <= pwdata[CFG_W-1:0];
            end else begin
                r_grid_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? APB_W'(r_grid_height)
                                                  : APB_W'(r_grid_width);

    crfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_action (s_tdata[OFS_ACTION +: 2]),
        .i_stat   (stat),
        .o_ready  (s_tready),
        .o_cmd    (cmd)
    );

    crfb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_s_tdata    (s_tdata),
        .i_cfg_width  (r_grid_width),
        .i_cfg_height (r_grid_height),
        .i_m_tready   (m_tready),
        .o_m_tvalid   (m_tvalid),
        .o_m_tdata    (m_tdata)
    );

endmodule

>>> hdl/crfb_checker.sv
// Port-level checks for the circle raster frame buffer, bound to the top level.
module crfb_checker
    import crfb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [CH_W-1:0]      m_tdata,
    input logic                 pready
);

    logic s_beat;
    assign s_beat = s_tvalid && s_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && (s_tdata[1:0] == ACT_READ) && !m_tvalid |-> ##3 m_tvalid)
        else $error("read result not presented on time");

    a_busy_after_paint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && ((s_tdata[1:0] == ACT_CLEAR) || (s_tdata[1:0] == ACT_DRAW))
        |=> !s_tready)
        else $error("input taken during a sweep");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a read in progress");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind circle_raster_frame_buffer crfb_checker u_crfb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
